// ===== hdl/c3rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// c3rgb_pkg
// Shared constants and types of the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package c3rgb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 24;
    localparam int COEF_W     = 48;
    localparam int LEVEL_W    = 24;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

    // packed pixel, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // one column of the kernel window
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } pcol_t;

    // a complete window plus the position of its output pixel
    typedef struct packed {
        pcol_t            left;
        pcol_t            centre;
        pcol_t            right;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } win_t;

endpackage

// ===== hdl/c3rgb_ram.sv =====
// ----------------------------------------------------------------------------
// c3rgb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module c3rgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held between reads
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/c3rgb_kernel.sv =====
// ----------------------------------------------------------------------------
// c3rgb_kernel
// Weighted 3x3 sum per channel and clamp or binarize, two register stages.
// ----------------------------------------------------------------------------
module c3rgb_kernel (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [c3rgb_pkg::COEF_W-1:0]    coef_top,
    input  logic [c3rgb_pkg::COEF_W-1:0]    coef_mid,
    input  logic [c3rgb_pkg::COEF_W-1:0]    coef_bot,
    input  logic [c3rgb_pkg::LEVEL_W-1:0]   level,
    input  logic                            mode,
    input  c3rgb_pkg::win_t                 win,
    input  logic                            win_valid,
    output logic                            win_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_blue,
    output logic [7:0]                      m_out_green,
    output logic [7:0]                      m_out_red,
    output logic [c3rgb_pkg::ROW_W-1:0]     m_out_row,
    output logic [c3rgb_pkg::COL_W-1:0]     m_out_col,
    output logic                            m_last_in_run
);
    import c3rgb_pkg::*;

    localparam int PROD_W = 24;
    localparam int SUM_W  = 28;

    logic                      mv_reg;
    logic signed [PROD_W-1:0]  prod_reg [3][3][3];
    logic signed [PROD_W-1:0]  prod_next [3][3][3];
    logic [ROW_W-1:0]          mrow_reg;
    logic [COL_W-1:0]          mcol_reg;
    logic                      mlast_reg;
    logic                      ov_reg;
    logic [7:0]                ch_reg [3];
    logic [7:0]                ch_next [3];
    logic [ROW_W-1:0]          orow_reg;
    logic [COL_W-1:0]          ocol_reg;
    logic                      olast_reg;
    logic                      o_adv;
    logic                      p_adv;
    pix_t                      taps [3][3];
    logic [COEF_W-1:0]         coefs [3];

    // finishing of one channel sum
    function automatic logic [7:0] finish(input logic signed [SUM_W-1:0] s,
                                          input logic mode_i,
                                          input logic [LEVEL_W-1:0] lvl);
        logic signed [SUM_W-1:0] lv;
        logic signed [SUM_W-1:0] rnd;
        lv  = SUM_W'($signed(lvl));
        rnd = s + SUM_W'(128);
        if (mode_i) begin
            finish = (s > lv) ? 8'd255 : 8'd0;
        end else if (s < 0) begin
            finish = 8'd0;
        end else if (s > SUM_W'(255 * 256)) begin
            finish = 8'd255;
        end else begin
            finish = rnd[15:8];
        end
    endfunction

    // stall control
    assign o_adv     = !ov_reg || m_ready;
    assign p_adv     = !mv_reg || o_adv;
    assign win_ready = p_adv;

    // window taps and weights
    always_comb begin
        taps[0][0] = win.left.top;
        taps[0][1] = win.centre.top;
        taps[0][2] = win.right.top;
        taps[1][0] = win.left.mid;
        taps[1][1] = win.centre.mid;
        taps[1][2] = win.right.mid;
        taps[2][0] = win.left.bot;
        taps[2][1] = win.centre.bot;
        taps[2][2] = win.right.bot;
        coefs[0]   = coef_top;
        coefs[1]   = coef_mid;
        coefs[2]   = coef_bot;
    end

    // products of every tap and channel
    always_comb begin
        logic signed [15:0] wt;
        logic [7:0]         px;
        logic signed [24:0] pr;
        wt = '0;
        px = '0;
        pr = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                wt = $signed(coefs[r][16*c +: 16]);
                for (int ch = 0; ch < 3; ch++) begin
                    px = taps[r][c][8*ch +: 8];
                    pr = $signed({1'b0, px}) * wt;
                    prod_next[r][c][ch] = pr[PROD_W-1:0];
                end
            end
        end
    end

    // sums and finishing
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    acc = acc + SUM_W'(prod_reg[r][c][ch]);
                end
            end
            ch_next[ch] = finish(acc, mode, level);
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (p_adv) begin
            mv_reg <= win_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_adv && win_valid) begin
            prod_reg  <= prod_next;
            mrow_reg  <= win.row;
            mcol_reg  <= win.col;
            mlast_reg <= win.last;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (o_adv) begin
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_adv && mv_reg) begin
            ch_reg    <= ch_next;
            orow_reg  <= mrow_reg;
            ocol_reg  <= mcol_reg;
            olast_reg <= mlast_reg;
        end
    end

    assign m_valid       = ov_reg;
    assign m_out_blue    = ch_reg[0];
    assign m_out_green   = ch_reg[1];
    assign m_out_red     = ch_reg[2];
    assign m_out_row     = orow_reg;
    assign m_out_col     = ocol_reg;
    assign m_last_in_run = olast_reg;

endmodule

// ===== hdl/conv3x3_rgb_clamp_or_binarize.sv =====
// ----------------------------------------------------------------------------
// conv3x3_rgb_clamp_or_binarize
// 3x3 convolution of an RGB raster stream with clamp or binarize output.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat each; results leave one beat per
// cycle while m_ready is high, row q while row q+1 arrives, and the last row
// of a frame as its own pixels arrive. A pixel beat causes zero to four
// results and stalls the input until they are issued, as the single result
// port sets the pace; the kernel takes a new window every cycle unless
// stalled. Beats pass stage one, the job register and the kernel's product
// and output stages. The three line stores, 2048-pixel RAM banks read at
// the incoming column, are not cleared after reset and need no clearing.
module conv3x3_rgb_clamp_or_binarize (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [c3rgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c3rgb_pkg::COEF_W-1:0]    cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_in_blue,
    input  logic [7:0]                      s_in_green,
    input  logic [7:0]                      s_in_red,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_blue,
    output logic [7:0]                      m_out_green,
    output logic [7:0]                      m_out_red,
    output logic [c3rgb_pkg::ROW_W-1:0]     m_out_row,
    output logic [c3rgb_pkg::COL_W-1:0]     m_out_col,
    output logic                            m_last_in_run
);
    import c3rgb_pkg::*;

    logic [COEF_W-1:0]  coef_top_reg;
    logic [COEF_W-1:0]  coef_mid_reg;
    logic [COEF_W-1:0]  coef_bot_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               mode_reg;
    logic [FW_W-1:0]    fwidth_reg;
    logic [FH_W-1:0]    fheight_reg;

    logic [FW_W-1:0]    w_eff;
    logic [FH_W-1:0]    h_eff;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [1:0]         slot_reg;
    logic [1:0]         slot_next;
    logic               restart;
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [1:0]         cur_slot;
    logic               at_last_col;
    logic               at_last_row;
    logic               s_accept;
    pix_t               in_pix;
    logic [PIX_W-1:0]   bank_q [3];

    logic               s1_valid_reg;
    pix_t               s1_pix_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [3:0]         s1_emit_reg;
    logic               s1_ge1_reg;
    logic               s1_ge2_reg;
    logic [1:0]         s1_sm1_reg;
    logic [1:0]         s1_sm2_reg;
    logic               s1_retire;
    pcol_t              cur_colv;
    pcol_t              h1_reg;
    pcol_t              h2_reg;

    logic               j_valid_reg;
    logic [3:0]         j_pend_reg;
    pcol_t              j_l2_reg;
    pcol_t              j_l1_reg;
    pcol_t              j_c0_reg;
    logic [ROW_W-1:0]   j_row_reg;
    logic [COL_W-1:0]   j_col_reg;
    logic [3:0]         j_pick;
    logic [3:0]         j_rest;
    logic               j_issue;
    logic               j_free;
    win_t               win;
    pcol_t              sel_l2;
    pcol_t              sel_l1;
    pcol_t              sel_c0;
    logic               win_ready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= '0;
            coef_mid_reg <= COEF_W'(48'h000001000000);
            coef_bot_reg <= '0;
            level_reg    <= '0;
            mode_reg     <= 1'b0;
            fwidth_reg   <= FW_W'(640);
            fheight_reg  <= FH_W'(480);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COEF_TOP: coef_top_reg <= cfg_data;
                REG_COEF_MID: coef_mid_reg <= cfg_data;
                REG_COEF_BOT: coef_bot_reg <= cfg_data;
                REG_LEVEL:    level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_MODE:     mode_reg     <= cfg_data[0];
                REG_WIDTH:    fwidth_reg   <= cfg_data[FW_W-1:0];
                REG_HEIGHT:   fheight_reg  <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (fwidth_reg == '0) begin
            w_eff = FW_W'(1);
        end else if (fwidth_reg > FW_W'(MAX_WIDTH)) begin
            w_eff = FW_W'(MAX_WIDTH);
        end else begin
            w_eff = fwidth_reg;
        end
        if (fheight_reg == '0) begin
            h_eff = FH_W'(1);
        end else if (fheight_reg > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = fheight_reg;
        end
    end

    // raster position of the incoming pixel
    assign s_ready  = !s1_valid_reg || s1_retire;
    assign s_accept = s_valid && s_ready;
    assign in_pix   = '{red: s_in_red, green: s_in_green, blue: s_in_blue};

    always_comb begin
        restart     = ({1'b0, row_reg} >= h_eff) || ({1'b0, col_reg} >= w_eff);
        cur_row     = restart ? '0 : row_reg;
        cur_col     = restart ? '0 : col_reg;
        cur_slot    = restart ? 2'd0 : slot_reg;
        at_last_col = ({1'b0, cur_col} == (w_eff - FW_W'(1)));
        at_last_row = ({1'b0, cur_row} == (h_eff - FH_W'(1)));
        row_next    = cur_row;
        col_next    = cur_col + COL_W'(1);
        slot_next   = cur_slot;
        if (at_last_col) begin
            col_next = '0;
            if (at_last_row) begin
                row_next  = '0;
                slot_next = 2'd0;
            end else begin
                row_next  = cur_row + ROW_W'(1);
                slot_next = (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= 2'd0;
        end else if (s_accept) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

    // line store banks, one per row slot
    for (genvar b = 0; b < 3; b++) begin : g_bank
        c3rgb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk     (aclk),
            .wr_en   (s_accept && (cur_slot == 2'(b))),
            .wr_addr (cur_col),
            .wr_data (in_pix),
            .rd_en   (s_accept),
            .rd_addr (cur_col),
            .rd_data (bank_q[b])
        );
    end

    // stage one: pixel waiting for its column from the banks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg  <= in_pix;
            s1_row_reg  <= cur_row;
            s1_col_reg  <= cur_col;
            s1_emit_reg <= {at_last_row && at_last_col,
                            at_last_row && (cur_col != '0),
                            (cur_row != '0) && at_last_col,
                            (cur_row != '0) && (cur_col != '0)};
            s1_ge1_reg  <= (cur_row != '0);
            s1_ge2_reg  <= (cur_row > ROW_W'(1));
            s1_sm1_reg  <= (cur_slot == 2'd0) ? 2'd2 : cur_slot - 2'd1;
            s1_sm2_reg  <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
        end
    end

    // column of rows r-2, r-1, r clamped at the top edge
    always_comb begin
        cur_colv.bot = s1_pix_reg;
        cur_colv.mid = s1_ge1_reg ? pix_t'(bank_q[s1_sm1_reg]) : s1_pix_reg;
        cur_colv.top = s1_ge2_reg ? pix_t'(bank_q[s1_sm2_reg]) : cur_colv.mid;
    end

    assign s1_retire = s1_valid_reg && ((s1_emit_reg == 4'b0000) || j_free);

    // history of the two previous columns
    always_ff @(posedge aclk) begin
        if (s1_retire) begin
            h1_reg <= cur_colv;
            h2_reg <= h1_reg;
        end
    end

    // job sequencer: issues the results of one pixel in order
    always_comb begin
        j_pick = j_pend_reg & (~j_pend_reg + 4'd1);
        j_rest = j_pend_reg & ~j_pick;
        j_issue = j_valid_reg && win_ready;
        j_free  = !j_valid_reg || (j_issue && (j_rest == 4'b0000));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_valid_reg <= 1'b0;
            j_pend_reg  <= 4'b0000;
        end else if (s1_retire && (s1_emit_reg != 4'b0000)) begin
            j_valid_reg <= 1'b1;
            j_pend_reg  <= s1_emit_reg;
        end else if (j_issue) begin
            j_valid_reg <= (j_rest != 4'b0000);
            j_pend_reg  <= j_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_retire && (s1_emit_reg != 4'b0000)) begin
            j_l2_reg  <= (s1_col_reg > COL_W'(1)) ? h2_reg :
                         ((s1_col_reg != '0) ? h1_reg : cur_colv);
            j_l1_reg  <= (s1_col_reg != '0) ? h1_reg : cur_colv;
            j_c0_reg  <= cur_colv;
            j_row_reg <= s1_row_reg;
            j_col_reg <= s1_col_reg;
        end
    end

    // window of the selected result
    always_comb begin
        sel_l2 = j_l2_reg;
        sel_l1 = j_l1_reg;
        sel_c0 = j_c0_reg;
        win    = '0;
        if (j_pick[1] || j_pick[3]) begin
            sel_l2 = j_l1_reg;
            sel_l1 = j_c0_reg;
            sel_c0 = j_c0_reg;
        end
        win.left   = sel_l2;
        win.centre = sel_l1;
        win.right  = sel_c0;
        win.row    = j_row_reg;
        win.col    = j_col_reg;
        if (j_pick[0] || j_pick[1]) begin
            win.row = j_row_reg - ROW_W'(1);
        end else begin
            // last row: rows r-1, r, r
            win.left.top   = sel_l2.mid;
            win.left.mid   = sel_l2.bot;
            win.centre.top = sel_l1.mid;
            win.centre.mid = sel_l1.bot;
            win.right.top  = sel_c0.mid;
            win.right.mid  = sel_c0.bot;
        end
        if (j_pick[0] || j_pick[2]) begin
            win.col = j_col_reg - COL_W'(1);
        end
        win.last = (j_rest == 4'b0000);
    end

    c3rgb_kernel u_kernel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .coef_top      (coef_top_reg),
        .coef_mid      (coef_mid_reg),
        .coef_bot      (coef_bot_reg),
        .level         (level_reg),
        .mode          (mode_reg),
        .win           (win),
        .win_valid     (j_valid_reg),
        .win_ready     (win_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_blue    (m_out_blue),
        .m_out_green   (m_out_green),
        .m_out_red     (m_out_red),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_in_run (m_last_in_run)
    );

endmodule
